/* hw/rtl/utf8_to_sjis_converter_core_assert.svh */
// Assertion macros used by the converter core RTL.
`ifndef UTF8_TO_SJIS_CONVERTER_CORE_ASSERT_SVH
`define UTF8_TO_SJIS_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U2S_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U2S_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* hw/rtl/u2s_pkg.sv */
// Shared types and constants of the UTF-8 to Shift-JIS converter.
`timescale 1ns / 1ps

package u2s_pkg;

  localparam int TABLE_DEPTH_DEF = 8192;
  localparam int ADDR_MAX_W      = 16;
  localparam int KEY_W           = 21;
  localparam int CODE_W          = 16;
  localparam int COUNT_W         = 14;
  localparam int INDEX_W         = 13;

  localparam logic [CODE_W-1:0] UNMAPPED_CODE = 16'h003F;
  localparam logic [7:0]        NEWLINE_BYTE  = 8'h0A;

  // Register index decoded from the APB address
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_t;

  // Table write request
  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [KEY_W-1:0]      key;
    logic [CODE_W-1:0]     code;
  } tbl_wr_t;

endpackage

/* hw/rtl/utf8_to_sjis_converter_core.sv */
// A table load writes the table memory on acceptance; a byte that needs no lookup passes
// through the emit state into the output register; a lookup adds a read and a compare
// state per probe of the table memory's single read port, at most ceil(log2(count+1))
// probes (14 for 8192). One item in flight: loads and lead bytes leave the sequencer idle;
// a byte with a result blocks input until a free output register takes its result.
// Reset clears the decoder, the entry count, the sequencer and the output valid; the
// table contents are not cleared and must be loaded before they are searched.
`timescale 1ns / 1ps

module utf8_to_sjis_converter_core #(
  parameter int TABLE_DEPTH = u2s_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: entry_index[12:0], entry_key[33:13], entry_code[49:34], text_byte[57:50]
  input  logic [63:0] in_tdata,
  // in_tuser: func (0 = table load, 1 = text byte)
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: sjis_code[15:0]
  output logic [15:0] out_tdata,
  // out_tuser: is_newline
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import u2s_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DIRECT,
    ACT_SEARCH
  } act_t;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] entry_count_r;
  logic [15:0]        pp_r, pp_nxt;
  logic [1:0]         pend_r, pend_nxt;
  logic [15:0]        cp_r, cp_nxt;
  logic [CODE_W-1:0]  res_code_r, res_code_nxt;
  logic               res_nl_r, res_nl_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CODE_W-1:0]  out_code_r, out_code_nxt;
  logic               out_nl_r, out_nl_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_acc, out_free, emit_load, rd_en;
  logic [7:0]         text_byte;
  tbl_wr_t            tbl_wr;
  logic [KEY_W-1:0]   rd_key;
  logic [CODE_W-1:0]  rd_code;

  act_t               dec_act;
  logic [15:0]        dec_val, dec_pp, dec_cp;
  logic [1:0]         dec_pend;
  logic               dec_nl;

  logic [CW-1:0]      n_eff, mid, lo_upd, hi_upd;
  logic [CW:0]        mid_sum;
  logic               key_hit, go_low, more;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ENTRY_COUNT) ? 32'(entry_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_ENTRY_COUNT) begin
      entry_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  // Saturate the search range to the table depth
  assign n_eff = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : CW'(entry_count_r);

  // ---------------- table ----------------
  assign in_acc    = in_tvalid && in_tready;
  assign text_byte = in_tdata[57:50];

  always_comb begin
    tbl_wr.en   = in_acc && !in_tuser && (32'(in_tdata[12:0]) < 32'(TABLE_DEPTH));
    tbl_wr.addr = ADDR_MAX_W'(in_tdata[12:0]);
    tbl_wr.key  = in_tdata[33:13];
    tbl_wr.code = in_tdata[49:34];
  end

  u2s_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .rd_en  (rd_en),
    .rd_addr(mid[AW-1:0]),
    .rd_key (rd_key),
    .rd_code(rd_code)
  );

  // ---------------- UTF-8 decoder ----------------
  always_comb begin
    dec_act  = ACT_NONE;
    dec_val  = '0;
    dec_nl   = 1'b0;
    dec_pp   = pp_r;
    dec_pend = pend_r;
    dec_cp   = pp_r | {10'd0, text_byte[5:0]};
    if (pend_r == 2'd2) begin
      dec_pp   = pp_r | {4'd0, text_byte[5:0], 6'd0};
      dec_pend = 2'd1;
    end else if (pend_r != 2'd0) begin
      // final continuation: complete the code point
      dec_pp   = '0;
      dec_pend = 2'd0;
      dec_val  = dec_cp;
      dec_act  = (dec_cp < 16'h0080) ? ACT_DIRECT : ACT_SEARCH;
    end else if (text_byte == NEWLINE_BYTE) begin
      dec_act = ACT_DIRECT;
      dec_val = {8'd0, NEWLINE_BYTE};
      dec_nl  = 1'b1;
    end else if (text_byte < 8'h80) begin
      dec_act = ACT_DIRECT;
      dec_val = {8'd0, text_byte};
    end else if (text_byte >= 8'hC0 && text_byte < 8'hE0) begin
      dec_pp   = {5'd0, text_byte[4:0], 6'd0};
      dec_pend = 2'd1;
    end else if (text_byte >= 8'hE0 && text_byte < 8'hF0) begin
      dec_pp   = {text_byte[3:0], 12'd0};
      dec_pend = 2'd2;
    end else begin
      // stray continuation, four-byte lead or invalid byte
      dec_act = ACT_DIRECT;
      dec_val = UNMAPPED_CODE;
    end
  end

  // ---------------- search probe ----------------
  assign mid_sum = (CW+1)'(lo_r) + (CW+1)'(hi_r) - (CW+1)'(1);
  assign mid     = mid_sum[CW:1];
  assign key_hit = (rd_key == {5'd0, cp_r});
  assign go_low  = ({5'd0, cp_r} < rd_key);
  assign lo_upd  = go_low ? lo_r : mid + CW'(1);
  assign hi_upd  = go_low ? mid : hi_r;
  assign more    = (lo_upd < hi_upd);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser) begin
          case (dec_act)
            ACT_DIRECT: state_nxt = ST_EMIT;
            ACT_SEARCH: state_nxt = (n_eff != '0) ? ST_READ : ST_EMIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = (key_hit || !more) ? ST_EMIT : ST_READ;
      ST_EMIT: state_nxt = out_free ? ST_IDLE : ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    in_tready = (state_r == ST_IDLE);
    rd_en     = (state_r == ST_READ);
    emit_load = (state_r == ST_EMIT) && out_free;
  end

  // ---------------- datapath ----------------
  always_comb begin
    pp_nxt        = pp_r;
    pend_nxt      = pend_r;
    cp_nxt        = cp_r;
    res_code_nxt  = res_code_r;
    res_nl_nxt    = res_nl_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_code_nxt  = out_code_r;
    out_nl_nxt    = out_nl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (state_r == ST_IDLE && in_acc && in_tuser) begin
      pp_nxt       = dec_pp;
      pend_nxt     = dec_pend;
      cp_nxt       = dec_val;
      res_nl_nxt   = dec_nl;
      // a search starts as a miss until a probe hits
      res_code_nxt = (dec_act == ACT_SEARCH) ? '0 : dec_val;
      lo_nxt       = '0;
      hi_nxt       = n_eff;
    end
    if (state_r == ST_CMP) begin
      if (key_hit) begin
        res_code_nxt = rd_code;
      end else begin
        lo_nxt = lo_upd;
        hi_nxt = hi_upd;
      end
    end
    if (emit_load) begin
      out_code_nxt  = (res_code_r == '0) ? UNMAPPED_CODE : res_code_r;
      out_nl_nxt    = res_nl_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pp_r        <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pp_r        <= pp_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r       <= cp_nxt;
    res_code_r <= res_code_nxt;
    res_nl_r   <= res_nl_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_code_r <= out_code_nxt;
    out_nl_r   <= out_nl_nxt;
  end

  assign out_tdata  = out_code_r;
  assign out_tuser  = out_nl_r;
  assign out_tvalid = out_valid_r;

  // ---------------- assertions ----------------
  `include "utf8_to_sjis_converter_core_assert.svh"

  `U2S_ASSERT_NEXT(a_read_then_cmp, state_r == ST_READ, state_r == ST_CMP, "probe read not compared")
  `U2S_ASSERT_NOW(a_probe_range, state_r == ST_READ || state_r == ST_CMP, lo_r < hi_r, "empty probe range")
  `U2S_ASSERT_NEXT(a_emit_load, emit_load, out_valid_r && state_r == ST_IDLE, "result not loaded")
  `U2S_ASSERT_NEXT(a_decoder_hold, state_r != ST_IDLE, $stable(pend_r) && $stable(pp_r), "decoder moved while busy")

endmodule

/* hw/rtl/u2s_table.sv */
// Mapping table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module u2s_table #(
  parameter int TABLE_DEPTH = u2s_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                        clk,
  input  u2s_pkg::tbl_wr_t            wr,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [u2s_pkg::KEY_W-1:0]   rd_key,
  output logic [u2s_pkg::CODE_W-1:0]  rd_code
);
  import u2s_pkg::*;

  logic [KEY_W+CODE_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+CODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= {wr.key, wr.code};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_key  = rd_data_r[KEY_W+CODE_W-1:CODE_W];
  assign rd_code = rd_data_r[CODE_W-1:0];

endmodule
